[design/tne_pkg.sv]
// Package for the triangle normal engine: controller states and the command/status
// structs that join the controller to the datapath. No dependencies.
`default_nettype none
package tne_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_EDGE,
      ST_CROSS,
      ST_NORM,
      ST_SQRT,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_UNWRIT = 2'd2;
   localparam logic [1:0] STATUS_ZERO   = 2'd3;

   typedef struct packed {
      logic       take;      // latch the request fields
      logic       vtx_write; // store the vertex at vertex_count
      logic [1:0] rd_sel;    // 0 a, 1 b, 2 c: capture read data of that corner
      logic       rd_issue;  // present the corner address to the store
      logic       edge_go;
      logic       cross_go;
      logic       norm_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_kind;
      logic       rsp_normals;
      logic       tri_count;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic full;
      logic unwritten;
      logic zero;
      logic norm_done;
      logic sqrt_done;
      logic div_done;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

[design/triangle_normal_engine.sv]
// Top level of the triangle normal engine: controller plus datapath.
// Depends on tne_pkg, tne_ctrl and tne_dp.
//
//   channel   handshake             payload
//   req       req_valid/req_stall   op, pos_x/y/z, corner_a/b/c
//   rsp       rsp_valid/rsp_stall   kind, assigned_index, normal_x/y/z, status
//
// Steps: a vertex or a rejected triangle needs no corner fetch; a degenerate
// one ends after fetch/cross; a normal adds 0 to 30 scaling shifts, squares,
// a 32-step root, the shared divider (48 steps x 3) and the output load.
// Reset clears counts and control; the vertex memory is not cleared.
// A stalled result is held; a new item is taken only once the result
// register is free or being drained.
`default_nettype none
module triangle_normal_engine
   import tne_pkg::*;
#(
   parameter int VERTEX_DEPTH        = 1024,
   parameter int TRIANGLE_INDEX_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_op,
   input  wire signed [15:0] req_pos_x,
   input  wire signed [15:0] req_pos_y,
   input  wire signed [15:0] req_pos_z,
   input  wire        [9:0]  req_corner_a,
   input  wire        [9:0]  req_corner_b,
   input  wire        [9:0]  req_corner_c,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_kind,
   output logic       [15:0] rsp_assigned_index,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic       [1:0]  rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   tne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tne_dp #(
      .VERTEX_DEPTH        (VERTEX_DEPTH),
      .TRIANGLE_INDEX_BITS (TRIANGLE_INDEX_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_corner_a       (req_corner_a),
      .req_corner_b       (req_corner_b),
      .req_corner_c       (req_corner_c),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_normal_x       (rsp_normal_x),
      .rsp_normal_y       (rsp_normal_y),
      .rsp_normal_z       (rsp_normal_z),
      .rsp_status         (rsp_status),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule
`default_nettype wire

[design/tne_ctrl.sv]
// Controller state machine for the triangle normal engine.
// Depends on tne_pkg.
`default_nettype none
module tne_ctrl
   import tne_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = stat.rsp_busy;
            if (req_valid && !stat.rsp_busy) begin
               cmd.take = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            if (!stat.op) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = 1'b0;
               cmd.vtx_write  = !stat.full;
               cmd.rsp_status = stat.full ? STATUS_FULL : STATUS_OK;
               state_in       = ST_IDLE;
            end else if (stat.unwritten) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = 1'b1;
               cmd.rsp_status = STATUS_UNWRIT;
               state_in       = ST_IDLE;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_sel   = 2'd0;
               state_in     = ST_RD_B;
            end
         end
         ST_RD_B: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = 2'd1;
            state_in     = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = 2'd2;
            state_in     = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_go = 1'b1;
            state_in    = ST_CROSS;
         end
         ST_CROSS: begin
            cmd.cross_go = 1'b1;
            state_in     = ST_NORM;
         end
         ST_NORM: begin
            if (stat.zero) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = 1'b1;
               cmd.rsp_status = STATUS_ZERO;
               cmd.tri_count  = 1'b1;
               state_in       = ST_IDLE;
            end else if (stat.norm_done) begin
               cmd.sqrt_init = 1'b1;
               state_in      = ST_SQRT;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_SQRT: begin
            if (stat.sqrt_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_OUT;
            else               cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            cmd.rsp_load    = 1'b1;
            cmd.rsp_kind    = 1'b1;
            cmd.rsp_status  = STATUS_OK;
            cmd.rsp_normals = 1'b1;
            cmd.tri_count   = 1'b1;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[design/tne_dp.sv]
// Datapath for the triangle normal engine: vertex memory, cross product, scaling,
// bit-serial square root, shared restoring divider and output register. Uses tne_pkg.
`default_nettype none
module tne_dp
   import tne_pkg::*;
#(
   parameter int VERTEX_DEPTH        = 1024,
   parameter int TRIANGLE_INDEX_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_op,
   input  wire signed [15:0] req_pos_x,
   input  wire signed [15:0] req_pos_y,
   input  wire signed [15:0] req_pos_z,
   input  wire        [9:0]  req_corner_a,
   input  wire        [9:0]  req_corner_b,
   input  wire        [9:0]  req_corner_c,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_kind,
   output logic       [15:0] rsp_assigned_index,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic       [1:0]  rsp_status,
   input  wire cmd_type      cmd,
   output stat_type          stat
);

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int CW = $clog2(VERTEX_DEPTH + 1);
   localparam int TW = TRIANGLE_INDEX_BITS;

   // request latch
   logic        op_ff;
   logic [47:0] pos_ff;
   logic [9:0]  ca_ff, cb_ff, cc_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_op;
         pos_ff <= {req_pos_z, req_pos_y, req_pos_x};
         ca_ff  <= req_corner_a;
         cb_ff  <= req_corner_b;
         cc_ff  <= req_corner_c;
      end
   end

   // counters
   logic [CW-1:0] vcnt_ff;
   logic [TW-1:0] tcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff <= '0;
         tcnt_ff <= '0;
      end else begin
         if (cmd.vtx_write) vcnt_ff <= vcnt_ff + 1'b1;
         if (cmd.tri_count) tcnt_ff <= tcnt_ff + 1'b1;
      end
   end

   logic [16:0] vcnt_w;
   assign vcnt_w = 17'(vcnt_ff);
   assign stat.op        = op_ff;
   assign stat.full      = (vcnt_w >= 17'(VERTEX_DEPTH));
   assign stat.unwritten = (17'(ca_ff) >= vcnt_w) || (17'(cb_ff) >= vcnt_w) ||
                           (17'(cc_ff) >= vcnt_w);

   // vertex memory
   logic [47:0] mem [VERTEX_DEPTH];
   logic [47:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic [1:0]  rsel_ff;
   logic        rvalid_ff;

   always_comb begin
      case (cmd.rd_sel)
         2'd0:    raddr = AW'(ca_ff);
         2'd1:    raddr = AW'(cb_ff);
         default: raddr = AW'(cc_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.vtx_write) mem[vcnt_ff[AW-1:0]] <= pos_ff;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else       rvalid_ff <= cmd.rd_issue;
      rsel_ff <= cmd.rd_sel;
   end

   logic [47:0] va_ff, vb_ff, vc_ff;
   always_ff @(posedge clock) begin
      if (rvalid_ff) begin
         case (rsel_ff)
            2'd0:    va_ff <= rdata_ff;
            2'd1:    vb_ff <= rdata_ff;
            default: vc_ff <= rdata_ff;
         endcase
      end
   end

   // edges (rdata of corner c lands in vc at the end of EDGE, so edges use the live value)
   logic signed [16:0] e1_ff [3];
   logic signed [16:0] e2_ff [3];
   logic [47:0] vc_live;
   assign vc_live = (rvalid_ff && rsel_ff == 2'd2) ? rdata_ff : vc_ff;

   always_ff @(posedge clock) begin
      if (cmd.edge_go) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= 17'(signed'(vb_ff[16*i +: 16])) - 17'(signed'(va_ff[16*i +: 16]));
            e2_ff[i] <= 17'(signed'(vc_live[16*i +: 16])) - 17'(signed'(va_ff[16*i +: 16]));
         end
      end
   end

   // cross product: six 17x17 products, then subtract in the scale stage
   logic signed [33:0] pp_ff [6];
   always_ff @(posedge clock) begin
      if (cmd.cross_go) begin
         pp_ff[0] <= e1_ff[1] * e2_ff[2];
         pp_ff[1] <= e1_ff[2] * e2_ff[1];
         pp_ff[2] <= e1_ff[2] * e2_ff[0];
         pp_ff[3] <= e1_ff[0] * e2_ff[2];
         pp_ff[4] <= e1_ff[0] * e2_ff[1];
         pp_ff[5] <= e1_ff[1] * e2_ff[0];
      end
   end

   logic signed [34:0] cr [3];
   logic [34:0]        cmag [3];
   logic [2:0]         cneg;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cr[i]   = 35'(pp_ff[2*i]) - 35'(pp_ff[2*i+1]);
         cneg[i] = cr[i][34];
         cmag[i] = cneg[i] ? 35'(-cr[i]) : 35'(cr[i]);
      end
   end

   // scaling: shift all magnitudes one bit per cycle until max in [2^30, 2^31)
   logic [34:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic        loaded_ff;
   logic [34:0] mmax;

   always_comb begin
      mmax = mag_ff[0];
      if (mag_ff[1] > mmax) mmax = mag_ff[1];
      if (mag_ff[2] > mmax) mmax = mag_ff[2];
   end

   assign stat.zero      = loaded_ff && (mmax == '0);
   assign stat.norm_done = loaded_ff && (mmax[34:30] == 5'b00001);

   always_ff @(posedge clock) begin
      if (reset) loaded_ff <= 1'b0;
      else if (cmd.cross_go) loaded_ff <= 1'b0;
      else if (!loaded_ff && cmd.norm_step) loaded_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.norm_step) begin
         if (!loaded_ff) begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= cmag[i];
            neg_ff <= cneg;
         end else if (mmax[34:31] != '0) begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end else begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
         end
      end
   end

   // sum of squares: one squaring per cycle
   // square root: two bits of radicand per cycle
   logic [1:0]  sq_idx_ff;
   logic [63:0] sum_ff;
   logic [63:0] rem_ff;
   logic [31:0] root_ff;
   logic [5:0]  sq_cnt_ff;
   logic        sq_phase_ff;
   logic [61:0] sq_prod_ff;
   logic [30:0] sq_op;

   // the accumulate step at index 3 only drains the last product
   assign sq_op = (sq_idx_ff == 2'd3) ? 31'd0 : mag_ff[sq_idx_ff][30:0];

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sq_idx_ff   <= 2'd0;
         sum_ff      <= '0;
         sq_phase_ff <= 1'b0;
         sq_cnt_ff   <= '0;
         rem_ff      <= '0;
         root_ff     <= '0;
         sq_prod_ff  <= '0;
      end else if (cmd.sqrt_step) begin
         if (!sq_phase_ff) begin
            // product and accumulate, one component per step (last one adds the final product)
            sq_prod_ff <= 62'(sq_op) * 62'(sq_op);
            sum_ff     <= sum_ff + 64'(sq_prod_ff);
            if (sq_idx_ff == 2'd3) sq_phase_ff <= 1'b1;
            else                   sq_idx_ff   <= sq_idx_ff + 1'b1;
         end else begin
            logic [65:0] trial;
            logic [65:0] rnew;
            rnew  = {rem_ff, sum_ff[63:62]};
            trial = {32'd0, root_ff, 2'b01};
            if (rnew >= trial) begin
               rem_ff  <= 64'(rnew - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= 64'(rnew);
               root_ff <= {root_ff[30:0], 1'b0};
            end
            sum_ff    <= sum_ff << 2;
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
         end
      end
   end

   assign stat.sqrt_done = sq_phase_ff && (sq_cnt_ff == 6'd32);

   // divider: restoring, one quotient bit per cycle, components in turn
   logic [31:0] len;
   assign len = (root_ff == '0) ? 32'd1 : root_ff;

   logic [1:0]  dv_idx_ff;
   logic [5:0]  dv_cnt_ff;
   logic [46:0] dnum_ff;
   logic [32:0] drem_ff;
   logic [46:0] dquo_ff;
   logic [15:0] q_ff [3];
   logic        dv_done_ff;

   assign stat.div_done = dv_done_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dv_idx_ff  <= 2'd0;
         dv_cnt_ff  <= '0;
         dv_done_ff <= 1'b0;
         drem_ff    <= '0;
         dnum_ff    <= {mag_ff[0][31:0], 14'd0} + 47'(len >> 1);
      end else if (cmd.div_step) begin
         logic [32:0] r;
         r = {drem_ff[31:0], dnum_ff[46]};
         dnum_ff <= dnum_ff << 1;
         if (r >= 33'(len)) begin
            drem_ff <= r - 33'(len);
            dquo_ff <= {dquo_ff[45:0], 1'b1};
         end else begin
            drem_ff <= r;
            dquo_ff <= {dquo_ff[45:0], 1'b0};
         end
         if (dv_cnt_ff == 6'd47) begin
            q_ff[dv_idx_ff] <= dquo_ff[15:0];
            drem_ff         <= '0;
            dv_cnt_ff       <= '0;
            if (dv_idx_ff == 2'd2) dv_done_ff <= 1'b1;
            else begin
               dv_idx_ff <= dv_idx_ff + 1'b1;
               dnum_ff   <= {mag_ff[dv_idx_ff + 2'd1][31:0], 14'd0} + 47'(len >> 1);
            end
         end else begin
            dv_cnt_ff <= dv_cnt_ff + 1'b1;
         end
      end
   end

   // output register
   logic [15:0] nrm [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         nrm[i] = neg_ff[i] ? 16'(-q_ff[i]) : q_ff[i];
   end

   logic [15:0] idx_out;
   always_comb begin
      idx_out = '0;
      if (cmd.rsp_status == STATUS_OK || cmd.rsp_status == STATUS_ZERO) begin
         if (cmd.rsp_kind) idx_out = 16'(tcnt_ff);
         else              idx_out = 16'(vcnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd.rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_kind           <= cmd.rsp_kind;
         rsp_status         <= cmd.rsp_status;
         rsp_assigned_index <= idx_out;
         rsp_normal_x       <= cmd.rsp_normals ? nrm[0] : 16'd0;
         rsp_normal_y       <= cmd.rsp_normals ? nrm[1] : 16'd0;
         rsp_normal_z       <= cmd.rsp_normals ? nrm[2] : 16'd0;
      end
   end

   assign stat.rsp_busy = rsp_valid && rsp_stall;

endmodule
`default_nettype wire
